[rtl/gdr_pkg.sv]
package gdr_pkg;

    // fixed-point formats
    localparam int FRAC_BITS  = 8;
    localparam int ANGLE_BITS = 12;
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int QIDX_W     = ANGLE_BITS - 1;
    localparam int COORD_W    = 14;
    localparam int DIR_W      = 15;
    localparam int UNIT_W     = FRAC_BITS + 15;
    localparam int SIDE_W     = UNIT_W + 1;
    localparam int POS_W      = 10;
    localparam int LIM_W      = 9;
    localparam int WALL_W     = 8;

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
    localparam logic [DIR_W-1:0]   DIR_ONE   = DIR_W'(16384);
    localparam logic [UNIT_W-1:0]  UNIT_MAX  = UNIT_W'(1) << (UNIT_W - 1);

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 2'd2;

    typedef logic [DIR_W-1:0] sine_tab_t [0:QUARTER];

    // quarter-wave sine table, Q1.14, integer taylor series in Q2.30
    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint sum;
        for (int k = 0; k <= QUARTER; k++) begin
            x = (longint'(k) * 64'd1686629713 + longint'(QUARTER / 2)) >> (ANGLE_BITS - 2);
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 6; n++) begin
                term = (term * x2) >> 30;
                // series denominators (2n)(2n+1)
                case (n)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    default: term = term / 64'd156;
                endcase
                if ((n & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (longint'(sum) + 32768) >> 16;
            if (v > 16384)
                v = 16384;
            tab[k] = DIR_W'(v);
        end
        tab[0] = '0;
        tab[QUARTER] = DIR_ONE;
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage

[rtl/gdr_ifs.sv]
// request channel: map writes and ray casts
interface gdr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [7:0]  cell_value;
    logic [13:0] origin_x;
    logic [13:0] origin_y;
    logic [11:0] ray_angle;

    modport source (output valid, req_type, cell_x, cell_y, cell_value,
                    origin_x, origin_y, ray_angle, input ready);
    modport sink (input valid, req_type, cell_x, cell_y, cell_value,
                  origin_x, origin_y, ray_angle, output ready);
endinterface

// result channel: one item per cast
interface gdr_res_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        hit_vertical;
    logic [13:0] distance;
    logic [13:0] hit_x;
    logic [13:0] hit_y;
    logic [7:0]  wall_id;

    modport source (output valid, hit, hit_vertical, distance, hit_x, hit_y,
                    wall_id, input ready);
    modport sink (input valid, hit, hit_vertical, distance, hit_x, hit_y,
                  wall_id, output ready);
endinterface

// configuration write channel
interface gdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [13:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/grid_dda_ray_caster_core.sv]
// grid ray caster: walks one ray through a stored grid map, cell boundary by
// cell boundary, until it meets a non-empty cell or reaches max_distance.
// channels: req (sink) takes map writes (req_type 0) and casts (req_type 1);
//   res (source) gives one item per cast; cfg (sink) writes max_distance,
//   rows_used and cols_used, always ready.
// reset: the map is cleared by a pass over all MAP_DIM*MAP_DIM cells (4096 at
//   the default), one cell a cycle; req.ready stays low until it is done.
// sequence: a write goes into the map when it is accepted. a cast runs the
//   sine lookup (cosine, then sine), the two unit steps in the shared divider,
//   the initial side distances, one step per boundary crossed, with a map
//   read for each crossing inside the map in use, the hit point on a hit and
//   the load of the result.
// throughput: one item at a time; req.ready is high only while idle.
// a finished result sits in the output register while the next item is
//   taken; if res is stalled, a later cast waits at its end until the output
//   register is free.
module grid_dda_ray_caster_core #(
    parameter int MAP_DIM   = 64,
    parameter int CELL_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    gdr_req_if.sink    req,
    gdr_res_if.source  res,
    gdr_cfg_if.sink    cfg
);

    localparam int DEPTH  = MAP_DIM * MAP_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = gdr_pkg::COORD_W;
    localparam int FB     = gdr_pkg::FRAC_BITS;
    localparam int PW     = gdr_pkg::POS_W;
    localparam int SW     = gdr_pkg::SIDE_W;
    localparam int MUL_W  = gdr_pkg::DIR_W + SW;
    localparam int MAG_W  = MUL_W - 14;
    localparam logic [gdr_pkg::LIM_W-1:0] MAP_LIM = gdr_pkg::LIM_W'(MAP_DIM);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_TRIG1 = 4'd2;
    localparam logic [3:0] S_TRIG2 = 4'd3;
    localparam logic [3:0] S_DIVX  = 4'd4;
    localparam logic [3:0] S_DIVY  = 4'd5;
    localparam logic [3:0] S_SIDEX = 4'd6;
    localparam logic [3:0] S_SIDEY = 4'd7;
    localparam logic [3:0] S_STEP  = 4'd8;
    localparam logic [3:0] S_CHECK = 4'd9;
    localparam logic [3:0] S_HITX  = 4'd10;
    localparam logic [3:0] S_HITY  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // configuration registers
    logic [13:0] max_dist_reg;
    logic [6:0]  rows_used_reg;
    logic [6:0]  cols_used_reg;

    // cast datapath
    logic [CW-1:0]                ox_reg;
    logic [CW-1:0]                oy_reg;
    logic [gdr_pkg::ANGLE_BITS-1:0] angle_reg;
    logic [gdr_pkg::DIR_W-1:0]    dxm_reg;
    logic [gdr_pkg::DIR_W-1:0]    dym_reg;
    logic                         negx_reg;
    logic                         negy_reg;
    logic [gdr_pkg::UNIT_W-1:0]   ux_reg;
    logic [gdr_pkg::UNIT_W-1:0]   uy_reg;
    logic [SW-1:0]                lx_reg;
    logic [SW-1:0]                ly_reg;
    logic [PW-1:0]                ix_reg;
    logic [PW-1:0]                iy_reg;
    logic [SW-1:0]                dist_reg;
    logic                         vert_reg;
    logic                         hit_reg;
    logic [CELL_BITS-1:0]         wall_reg;
    logic [CW-1:0]                hx_reg;
    logic [CW-1:0]                hy_reg;

    // output register
    logic                         res_valid_reg;
    logic                         res_hit_reg;
    logic                         res_vert_reg;
    logic [CW-1:0]                res_dist_reg;
    logic [CW-1:0]                res_hx_reg;
    logic [CW-1:0]                res_hy_reg;
    logic [gdr_pkg::WALL_W-1:0]   res_wall_reg;

    // map memory and clear counter
    logic [CELL_BITS-1:0] map_mem [DEPTH];
    logic [CELL_BITS-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [CELL_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    // sine rom
    logic [gdr_pkg::QIDX_W-1:0] rom_addr;
    logic [gdr_pkg::DIR_W-1:0]  rom_q_reg;
    logic [1:0]                 quad_in;
    logic [1:0]                 quad_c;
    logic [gdr_pkg::ANGLE_BITS-3:0] ang_r;
    logic [gdr_pkg::ANGLE_BITS-3:0] ang_r_in;

    // shared divider and multiplier
    logic                         div_start;
    logic [gdr_pkg::DIR_W-1:0]    div_divisor;
    logic [gdr_pkg::UNIT_W-1:0]   div_quot;
    logic                         div_done;
    logic [gdr_pkg::DIR_W-1:0]    mul_a;
    logic [SW-1:0]                mul_b;
    logic [MUL_W-1:0]             prod;
    logic [MAG_W-1:0]             mag;

    // stepping
    logic                         req_acc;
    logic                         wr_in_map;
    logic                         take_x;
    logic [PW-1:0]                nx;
    logic [PW-1:0]                ny;
    logic [gdr_pkg::LIM_W-1:0]    lim_x;
    logic [gdr_pkg::LIM_W-1:0]    lim_y;
    logic                         in_map;
    logic                         loop_go;
    logic [FB:0]                  fx;
    logic [FB:0]                  fy;

    // origin plus or minus magnitude, clamped to the coordinate range
    function automatic logic [CW-1:0] move_pt(input logic [CW-1:0] org,
                                              input logic neg,
                                              input logic [MAG_W-1:0] m);
        logic [MAG_W:0] sum;
        logic [CW-1:0]  res_v;
        sum = {{(MAG_W+1-CW){1'b0}}, org} + {1'b0, m};
        if (neg)
            res_v = (m > MAG_W'(org)) ? '0 : CW'(MAG_W'(org) - m);
        else
            res_v = (sum > (MAG_W+1)'(gdr_pkg::COORD_MAX)) ? gdr_pkg::COORD_MAX : CW'(sum);
        return res_v;
    endfunction

    assign req_acc   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg  <= 14'd16383;
            rows_used_reg <= 7'd64;
            cols_used_reg <= 7'd64;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                gdr_pkg::CFG_MAX_DIST: max_dist_reg  <= cfg.data;
                gdr_pkg::CFG_ROWS:     rows_used_reg <= cfg.data[6:0];
                gdr_pkg::CFG_COLS:     cols_used_reg <= cfg.data[6:0];
                default:               ;
            endcase
        end
    end

    // sine rom address: cosine from the incoming angle, then sine
    assign quad_in  = req.ray_angle[gdr_pkg::ANGLE_BITS-1:gdr_pkg::ANGLE_BITS-2] + 2'd1;
    assign ang_r_in = req.ray_angle[gdr_pkg::ANGLE_BITS-3:0];
    assign ang_r    = angle_reg[gdr_pkg::ANGLE_BITS-3:0];
    assign quad_c   = angle_reg[gdr_pkg::ANGLE_BITS-1:gdr_pkg::ANGLE_BITS-2] + 2'd1;

    always_comb
    begin
        if (state_reg == S_IDLE)
            rom_addr = quad_in[0]
                ? gdr_pkg::QIDX_W'(gdr_pkg::QUARTER) - {1'b0, ang_r_in}
                : {1'b0, ang_r_in};
        else
            rom_addr = angle_reg[gdr_pkg::ANGLE_BITS-2]
                ? gdr_pkg::QIDX_W'(gdr_pkg::QUARTER) - {1'b0, ang_r}
                : {1'b0, ang_r};
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= gdr_pkg::SINE_TAB[rom_addr];
    end

    // map memory ports
    assign wr_in_map = ({3'b0, req.cell_x} < MAP_LIM) && ({3'b0, req.cell_y} < MAP_LIM);
    assign mem_we    = (state_reg == S_CLEAR) ||
                       (req_acc && req.req_type == gdr_pkg::REQ_WRITE && wr_in_map);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg
                     : ADDR_W'(ADDR_W'(req.cell_x) * ADDR_W'(MAP_DIM)) + ADDR_W'(req.cell_y);
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : CELL_BITS'(req.cell_value);
    assign mem_raddr = ADDR_W'(ADDR_W'(nx[gdr_pkg::LIM_W-1:0]) * ADDR_W'(MAP_DIM))
                     + ADDR_W'(ny[gdr_pkg::LIM_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= map_mem[mem_raddr];
    end

    // divider
    assign div_start   = (state_reg == S_TRIG2) || (state_reg == S_DIVX && div_done);
    assign div_divisor = (state_reg == S_TRIG2) ? dxm_reg : dym_reg;

    gdr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    // shared multiplier operands
    assign fx = negx_reg ? {1'b0, ox_reg[FB-1:0]} : (FB+1)'(1 << FB) - {1'b0, ox_reg[FB-1:0]};
    assign fy = negy_reg ? {1'b0, oy_reg[FB-1:0]} : (FB+1)'(1 << FB) - {1'b0, oy_reg[FB-1:0]};

    always_comb
    begin
        case (state_reg)
            S_SIDEX:
            begin
                mul_a = gdr_pkg::DIR_W'(fx);
                mul_b = SW'(ux_reg);
            end
            S_SIDEY:
            begin
                mul_a = gdr_pkg::DIR_W'(fy);
                mul_b = SW'(uy_reg);
            end
            S_HITX:
            begin
                mul_a = dxm_reg;
                mul_b = dist_reg;
            end
            default:
            begin
                mul_a = dym_reg;
                mul_b = dist_reg;
            end
        endcase
    end

    assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign mag  = prod[MUL_W-1:14];

    // next cell along the smaller side distance
    assign take_x = lx_reg < ly_reg;
    assign nx = take_x ? ix_reg + (negx_reg ? {PW{1'b1}} : PW'(1)) : ix_reg;
    assign ny = take_x ? iy_reg : iy_reg + (negy_reg ? {PW{1'b1}} : PW'(1));
    assign lim_x = ({2'b0, rows_used_reg} > MAP_LIM) ? MAP_LIM : {2'b0, rows_used_reg};
    assign lim_y = ({2'b0, cols_used_reg} > MAP_LIM) ? MAP_LIM : {2'b0, cols_used_reg};
    assign in_map = !nx[PW-1] && (nx[gdr_pkg::LIM_W-1:0] < lim_x) &&
                    !ny[PW-1] && (ny[gdr_pkg::LIM_W-1:0] < lim_y);
    assign loop_go = !hit_reg && (dist_reg < SW'(max_dist_reg));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (req_acc && req.req_type == gdr_pkg::REQ_CAST) state_next = S_TRIG1;
            S_TRIG1: state_next = S_TRIG2;
            S_TRIG2: state_next = S_DIVX;
            S_DIVX:  if (div_done) state_next = S_DIVY;
            S_DIVY:  if (div_done) state_next = S_SIDEX;
            S_SIDEX: state_next = S_SIDEY;
            S_SIDEY: state_next = S_STEP;
            S_STEP:
            begin
                if (!loop_go)
                    state_next = hit_reg ? S_HITX : S_DONE;
                else if (in_map)
                    state_next = S_CHECK;
            end
            S_CHECK: state_next = S_STEP;
            S_HITX:  state_next = S_HITY;
            S_HITY:  state_next = S_DONE;
            S_DONE:  if (!res_valid_reg || res.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == S_DONE && (!res_valid_reg || res.ready))
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // cast datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ox_reg    <= req.origin_x;
                oy_reg    <= req.origin_y;
                angle_reg <= req.ray_angle;
                ix_reg    <= PW'(req.origin_x[CW-1:FB]);
                iy_reg    <= PW'(req.origin_y[CW-1:FB]);
                hit_reg   <= 1'b0;
                vert_reg  <= 1'b0;
                dist_reg  <= '0;
            end
            S_TRIG1:
            begin
                dxm_reg  <= rom_q_reg;
                negx_reg <= quad_c[1] && (rom_q_reg != '0);
            end
            S_TRIG2:
            begin
                dym_reg  <= rom_q_reg;
                negy_reg <= angle_reg[gdr_pkg::ANGLE_BITS-1] && (rom_q_reg != '0);
            end
            S_DIVX:
                if (div_done)
                    ux_reg <= (dxm_reg == '0) ? gdr_pkg::UNIT_MAX : div_quot;
            S_DIVY:
                if (div_done)
                    uy_reg <= (dym_reg == '0) ? gdr_pkg::UNIT_MAX : div_quot;
            S_SIDEX: lx_reg <= SW'(prod >> FB);
            S_SIDEY: ly_reg <= SW'(prod >> FB);
            S_STEP:
            begin
                if (loop_go)
                begin
                    ix_reg <= nx;
                    iy_reg <= ny;
                    if (take_x)
                    begin
                        vert_reg <= 1'b1;
                        dist_reg <= lx_reg;
                        lx_reg   <= lx_reg + SW'(ux_reg);
                    end
                    else
                    begin
                        vert_reg <= 1'b0;
                        dist_reg <= ly_reg;
                        ly_reg   <= ly_reg + SW'(uy_reg);
                    end
                end
            end
            S_CHECK:
            begin
                if (mem_rdata_reg != '0)
                begin
                    hit_reg  <= 1'b1;
                    wall_reg <= mem_rdata_reg;
                end
            end
            S_HITX: hx_reg <= move_pt(ox_reg, negx_reg, mag);
            S_HITY: hy_reg <= move_pt(oy_reg, negy_reg, mag);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!res_valid_reg || res.ready))
        begin
            res_hit_reg  <= hit_reg;
            res_vert_reg <= vert_reg;
            res_dist_reg <= (dist_reg > SW'(gdr_pkg::COORD_MAX)) ? gdr_pkg::COORD_MAX
                                                                  : CW'(dist_reg);
            res_hx_reg   <= hit_reg ? hx_reg : '0;
            res_hy_reg   <= hit_reg ? hy_reg : '0;
            res_wall_reg <= hit_reg ? gdr_pkg::WALL_W'(wall_reg) : '0;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.hit          = res_hit_reg;
    assign res.hit_vertical = res_vert_reg;
    assign res.distance     = res_dist_reg;
    assign res.hit_x        = res_hx_reg;
    assign res.hit_y        = res_hy_reg;
    assign res.wall_id      = res_wall_reg;

    // checks
    a_no_req_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !req.ready)
        else $error("request taken during map clear");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVX || state_reg == S_DIVY))
        else $error("divider finished outside a divide state");

    a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> res.hit_x == '0 && res.hit_y == '0 && res.wall_id == '0)
        else $error("miss result carries hit fields");

    a_hit_wall_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.hit |-> res.wall_id != '0 || CELL_BITS > gdr_pkg::WALL_W)
        else $error("hit result with empty wall");

endmodule

[rtl/gdr_divider.sv]
// radix-2 restoring divider, constant numerator, one quotient bit a cycle
module gdr_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gdr_pkg::DIR_W-1:0]   divisor,
    output logic [gdr_pkg::UNIT_W-1:0]  quotient,
    output logic                        done
);

    localparam int CNT_W = $clog2(gdr_pkg::UNIT_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [gdr_pkg::DIR_W:0]     rem_reg;
    logic [gdr_pkg::UNIT_W-1:0]  quo_reg;
    logic [gdr_pkg::DIR_W-1:0]   div_reg;
    logic [gdr_pkg::DIR_W:0]     trial;
    logic                        fits;

    // shift in next numerator bit and try a subtract
    assign trial = {rem_reg[gdr_pkg::DIR_W-1:0], gdr_pkg::UNIT_MAX[cnt_reg]};
    assign fits  = trial >= {1'b0, div_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(gdr_pkg::UNIT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
            quo_reg <= {quo_reg[gdr_pkg::UNIT_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
